// ===== design/tcra_pkg.sv =====
package tcra_pkg;
  localparam int HistDepth = 128;
  localparam int SlotW = $clog2(HistDepth);
  localparam int CountW = $clog2(HistDepth + 1);
  localparam logic [7:0] WindowReset = 8'd100;
  localparam int SqW = 32;          // x^2+y^2+z^2+w^2 fits in 33 bits
  localparam int NW = 33;
  localparam int QW = 18;           // quotient up to 2^17
  localparam int TotW = 25;
  localparam int DivW = 51;         // dividend and quotient width of the divider

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StDiv  = 6'b000010,
    StMul  = 6'b000100,
    StRead = 6'b001000,
    StAvg  = 6'b010000,
    StHold = 6'b100000
  } state_e;
endpackage

// ===== design/tcra_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tcra_divider import tcra_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [NW-1:0]   divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);
  logic [DivW-1:0] quot_q, quot_d;
  logic [NW:0]   rem_q, rem_d;
  logic [NW-1:0] dvs_q, dvs_d;
  logic [5:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [NW:0]   shifted;
  logic [NW:0]   diff;

  assign shifted = {rem_q[NW-1:0], quot_q[DivW-1]};
  assign diff = shifted - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[NW]) begin
        rem_d = diff;
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quot_o = quot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end
endmodule

// ===== design/tilt_compensated_range_average_unit.sv =====
// Each word passes through the tilt-factor and averaging divides in the shared
// bit-serial divider, with the history read and update between them. A new word
// is taken only once the unit is idle again.
// The output register holds a waiting result while the next word is taken;
// that word then holds in the unit until the output register frees up.
// Reset: window length 100, history empty; the history RAM is not cleared.
module tilt_compensated_range_average_unit import tcra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48], tof_range[79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // altitude_avg[16:0], corrected_range[33:17], samples_used[41:34]
  output logic [47:0] m_axis_tdata,
  // bad_quaternion[0]
  output logic        m_axis_tuser
);
  state_e st_q, st_d;
  logic [7:0] win_q;
  logic [SlotW-1:0] slot_q;
  logic [CountW-1:0] fill_q;
  logic signed [TotW-1:0] tot_q;
  logic signed [17:0] hist_mem [HistDepth];
  logic signed [17:0] rd_q;

  logic [15:0] rng_q;
  logic [NW-1:0] n_q;
  logic bad_q;
  logic signed [17:0] corr_q;
  logic tot_neg_q;
  logic [CountW-1:0] eff_fill_q;
  logic [SlotW-1:0] wslot_q;
  logic out_v_q;
  logic [47:0] out_data_q;
  logic out_bad_q;

  logic signed [16:0] qx, qy, qz, qw;
  logic signed [31:0] sq_x, sq_y, sq_z, sq_w;
  logic [SqW-1:0] a_c;
  logic [NW-1:0] n_c;
  assign qx = 17'(signed'(s_axis_tdata[15:0]));
  assign qy = 17'(signed'(s_axis_tdata[31:16]));
  assign qz = 17'(signed'(s_axis_tdata[47:32]));
  assign qw = 17'(signed'(s_axis_tdata[63:48]));
  // squares of 16-bit values, each at most 2^30
  assign sq_x = qx * qx;
  assign sq_y = qy * qy;
  assign sq_z = qz * qz;
  assign sq_w = qw * qw;
  assign a_c = unsigned'(sq_x) + unsigned'(sq_y);
  assign n_c = NW'(a_c) + NW'(unsigned'(sq_z)) + NW'(unsigned'(sq_w));

  logic [CountW-1:0] win_eff;
  always_comb begin
    if (win_q == 8'd0) win_eff = CountW'(1);
    else if (32'(win_q) > HistDepth) win_eff = CountW'(HistDepth);
    else win_eff = CountW'(win_q);
  end

  logic div_start, div_done;
  logic [DivW-1:0] div_num, div_quot;
  logic [NW-1:0] div_den;

  tcra_divider u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // factor magnitude and corrected range
  logic signed [17:0] factor;
  logic [16:0] fmag;
  logic [32:0] prod;
  logic [16:0] pmag;
  assign factor = bad_q ? 18'sd65536 : 18'sd65536 - signed'(18'(div_quot));
  assign fmag = factor[17] ? 17'(-factor) : 17'(factor);
  assign prod = 33'(rng_q) * 33'(fmag);
  assign pmag = 17'((prod + 33'd32768) >> 16);

  logic [SlotW-1:0] slot_use;
  assign slot_use = (CountW'(slot_q) >= win_eff) ? '0 : slot_q;

  logic can_take;
  assign can_take = (st_q == StIdle);
  assign s_axis_tready = can_take;

  // load the result once the average is ready and the output register is free
  logic res_load;
  assign res_load = ((st_q == StAvg && div_done) || st_q == StHold)
                  && (!out_v_q || m_axis_tready);

  logic [CountW-1:0] fill_new;
  logic signed [TotW-1:0] tot_new;
  assign fill_new = (fill_q >= win_eff) ? win_eff : fill_q + CountW'(1);
  assign tot_new = tot_q + TotW'(corr_q)
                 - ((fill_q >= win_eff) ? TotW'(rd_q) : TotW'(0));

  always_comb begin
    st_d = st_q;
    div_start = 1'b0;
    div_num = '0;
    div_den = n_q;
    unique case (st_q)
      StIdle: if (s_axis_tvalid && can_take) begin
        st_d = StDiv;
        div_start = 1'b1;
        div_num = DivW'({a_c, 17'd0}) + DivW'(n_c >> 1);
        div_den = (n_c == '0) ? NW'(1) : n_c;
      end
      StDiv: if (div_done) st_d = StMul;
      StMul: st_d = StRead;
      StRead: begin
        st_d = StAvg;
        div_start = 1'b1;
        div_num = DivW'(unsigned'(tot_new[TotW-1] ? -tot_new : tot_new));
        div_den = NW'(fill_new);
      end
      StAvg: if (div_done) st_d = res_load ? StIdle : StHold;
      StHold: if (res_load) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      win_q <= WindowReset;
      slot_q <= '0;
      fill_q <= '0;
      tot_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
        slot_q <= '0;
        fill_q <= '0;
        tot_q <= '0;
      end else if (st_q == StRead) begin
        fill_q <= fill_new;
        tot_q <= tot_new;
        slot_q <= (CountW'(slot_use) + CountW'(1) >= win_eff) ? '0 : slot_use + SlotW'(1);
      end
    end
  end

  // history RAM: read old entry, write the corrected word back in the same slot
  always_ff @(posedge clk_i) begin
    if (st_q == StMul) rd_q <= hist_mem[slot_use];
    if (st_q == StRead) hist_mem[wslot_q] <= corr_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && can_take) begin
      rng_q <= s_axis_tdata[79:64];
      n_q <= (n_c == '0) ? NW'(1) : n_c;
      bad_q <= (n_c == '0);
    end
    if (st_q == StMul) begin
      corr_q <= factor[17] ? -18'(pmag) : 18'(pmag);
      wslot_q <= slot_use;
    end
    if (st_q == StRead) begin
      tot_neg_q <= tot_new[TotW-1];
      eff_fill_q <= fill_new;
    end
    if (res_load) begin
      out_data_q <= {6'd0, 8'(eff_fill_q), 17'(corr_q),
                     tot_neg_q ? 17'(-div_quot[16:0]) : div_quot[16:0]};
      out_bad_q <= bad_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_bad_q;

  // StMul is entered only after the factor divide finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StMul) |-> $past(st_q) == StDiv)
    else $error("mul without divide");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountW'(HistDepth))
    else $error("fill count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> out_v_q)
    else $error("result dropped");
endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcra_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  typedef struct packed {
    logic [16:0] altitude_avg;
    logic [16:0] corrected_range;
    logic [7:0]  samples_used;
    logic        bad_quaternion;
  } avg_result_t;

  // ring of expected results, written at input accept, read at output accept
  avg_result_t expected_avgs[2048];
  logic [10:0] exp_wr_ptr = '0;
  logic [10:0] exp_rd_ptr = '0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          long_hold = 1'b0;
  bit          sink_pattern = 1'b0;

  // predictor state
  logic signed [17:0] hist_mem[HistDepth];
  int unsigned        slot_ptr;
  int unsigned        fill_cnt;
  longint             sum_acc;
  logic [7:0]         win_reg;

  tilt_compensated_range_average_unit DUT (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void clear_predictor();
    slot_ptr = 0;
    fill_cnt = 0;
    sum_acc  = 0;
  endfunction

  function automatic avg_result_t predict_average(logic [79:0] word);
    longint x, y, z, w, rng, a, n, q, fac, mag, corr;
    int unsigned win;
    avg_result_t r;
    x = longint'($signed(word[15:0]));
    y = longint'($signed(word[31:16]));
    z = longint'($signed(word[47:32]));
    w = longint'($signed(word[63:48]));
    rng = longint'(word[79:64]);
    a = x * x + y * y;
    n = a + z * z + w * w;
    r.bad_quaternion = (n == 0);
    if (n == 0) fac = 65536;
    else begin
      q = ((a << 17) + (n >> 1)) / n;
      fac = 65536 - q;
    end
    if (fac >= 0) begin
      mag = rng * fac;
      corr = (mag + 32768) >>> 16;
    end else begin
      mag = rng * (-fac);
      corr = -((mag + 32768) >>> 16);
    end
    win = (win_reg == 0) ? 1 : ((win_reg > HistDepth) ? HistDepth : win_reg);
    if (slot_ptr >= win) slot_ptr = 0;
    if (fill_cnt >= win) begin
      sum_acc -= longint'(hist_mem[slot_ptr]);
      fill_cnt = win;
    end else fill_cnt++;
    hist_mem[slot_ptr] = 18'(corr);
    sum_acc += corr;
    slot_ptr++;
    if (slot_ptr >= win) slot_ptr = 0;
    r.altitude_avg    = 17'(sum_acc / longint'(fill_cnt));
    r.corrected_range = 17'(corr);
    r.samples_used    = 8'(fill_cnt);
    return r;
  endfunction

  // receiver: stall pattern, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (long_hold) m_axis_tready <= 1'b0;
    else if (sink_pattern) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    avg_result_t act, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      act = {m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tdata[41:34],
             m_axis_tuser};
      if (exp_wr_ptr == exp_rd_ptr) begin
        $display("%0t: unexpected word %h", $time, act);
        mismatches++;
      end else begin
        exp_r = expected_avgs[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + 11'd1;
        if (act.altitude_avg !== exp_r.altitude_avg)
          $display("%0t: altitude_avg exp %0d got %0d", $time,
                   $signed(exp_r.altitude_avg), $signed(act.altitude_avg));
        if (act.corrected_range !== exp_r.corrected_range)
          $display("%0t: corrected_range exp %0d got %0d", $time,
                   $signed(exp_r.corrected_range), $signed(act.corrected_range));
        if (act.samples_used !== exp_r.samples_used)
          $display("%0t: samples_used exp %0d got %0d", $time,
                   exp_r.samples_used, act.samples_used);
        if (act.bad_quaternion !== exp_r.bad_quaternion)
          $display("%0t: bad_quaternion exp %0b got %0b", $time,
                   exp_r.bad_quaternion, act.bad_quaternion);
        if (act !== exp_r) mismatches++;
      end
    end
  end

  task automatic send_sample(logic [15:0] qx, qy, qz, qw, rng);
    logic [79:0] word;
    word = {rng, qw, qz, qy, qx};
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_avgs[exp_wr_ptr] = predict_average(word);
    exp_wr_ptr = exp_wr_ptr + 11'd1;
    @(negedge clk_i);
  endtask

  task automatic gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 30)) @(negedge clk_i);
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_wr_ptr != exp_rd_ptr) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_window(logic [7:0] len);
    drain_and_idle();
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    win_reg = len;
    clear_predictor();
  endtask

  task automatic send_random_sample();
    logic [15:0] c[4];
    int kind;
    kind = $urandom_range(0, 9);
    foreach (c[i]) c[i] = 16'($urandom);
    if (kind == 0) c = '{16'h0, 16'h0, 16'h0, 16'h0};
    else if (kind == 1) begin
      // near level attitude
      c[0] = 16'($signed(11'($urandom)));
      c[1] = 16'($signed(11'($urandom)));
    end
    send_sample(c[0], c[1], c[2], c[3], 16'($urandom));
  endtask

  task automatic run_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_random_sample();
        count--;
      end
      if ($urandom_range(0, 2) == 0) gap();
    end
  endtask

  task automatic test_directed();
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'hffff);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_sample(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h1234);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send_sample(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_sample(16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'h8000);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'haaaa);
    send_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
  endtask

  task automatic test_window_extremes();
    write_window(8'd0);
    run_random(6);
    write_window(8'd1);
    run_random(6);
    write_window(8'd200);
    run_random(140);
    write_window(8'd255);
    run_random(20);
    write_window(8'd128);
    run_random(140);
    write_window(8'd2);
    run_random(10);
  endtask

  task automatic test_backpressure();
    write_window(8'd5);
    long_hold = 1'b1;
    fork
      run_random(20);
      begin
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
    join
  endtask

  task automatic test_random_windows();
    repeat (10) begin
      write_window(8'($urandom_range(1, 128)));
      run_random(100);
    end
  endtask

  initial begin
    win_reg = WindowReset;
    clear_predictor();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    sink_pattern = 1'b1;
    test_window_extremes();
    test_backpressure();
    test_random_windows();
    drain_and_idle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
design/tcra_pkg.sv
design/tcra_divider.sv
design/tilt_compensated_range_average_unit.sv
tb/sv/tb.sv
